@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define RHC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Check a property on every rising edge, reset cycles included.
`define RHC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/core/rhc_pkg.sv @@
// Types, constants and the divider step of the RGB to HSV converter.
// No dependencies; imported by the converter.
package rhc_pkg;

  localparam int COMP_W         = 8;
  localparam int SAT_W          = 16;
  localparam int HUE_W          = 16;
  localparam int HDIV_W         = 11;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = SAT_W / BITS_PER_STAGE;
  localparam int PIPE_DEPTH     = DIV_STAGES + 1;

  localparam logic [SAT_W-1:0] SAT_HOLD = 16'hFFFF;

  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              sat_full;
    logic              sat_zero;
    logic [COMP_W-1:0] sat_rem;
    logic [SAT_W-1:0]  sat_q;
    logic              hue_zero;
    logic [HDIV_W-1:0] hue_rem;
    logic [HDIV_W-1:0] hue_div;
    logic [HUE_W-1:0]  hue_q;
  } stage_t;

  // Produce BITS_PER_STAGE more quotient bits of both restoring divisions.
  function automatic stage_t div_advance(stage_t s);
    stage_t            o;
    logic [COMP_W:0]   sr2;
    logic [HDIV_W:0]   hr2;
    o = s;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      sr2 = {o.sat_rem, 1'b0};
      if (sr2 >= {1'b0, o.value}) begin
        o.sat_rem = COMP_W'(sr2 - {1'b0, o.value});
        o.sat_q   = {o.sat_q[SAT_W-2:0], 1'b1};
      end else begin
        o.sat_rem = sr2[COMP_W-1:0];
        o.sat_q   = {o.sat_q[SAT_W-2:0], 1'b0};
      end
      hr2 = {o.hue_rem, 1'b0};
      if (hr2 >= {1'b0, o.hue_div}) begin
        o.hue_rem = HDIV_W'(hr2 - {1'b0, o.hue_div});
        o.hue_q   = {o.hue_q[HUE_W-2:0], 1'b1};
      end else begin
        o.hue_rem = hr2[HDIV_W-1:0];
        o.hue_q   = {o.hue_q[HUE_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

@@ rtl/core/rhc_rgb_if.sv @@
// Pixel channel of the RGB to HSV converter: valid, ready, three components.
// Depends on rhc_pkg for the component width.
interface rhc_rgb_if import rhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/core/rhc_hsv_if.sv @@
// Result channel of the RGB to HSV converter: valid, ready, hue, saturation, value.
// Depends on rhc_pkg for the field widths.
interface rhc_hsv_if import rhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [SAT_W-1:0]  saturation;
  logic [COMP_W-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

@@ rtl/core/rgb_to_hsv_converter.sv @@
// RGB to HSV converter, top level.
// Depends on rhc_pkg, rhc_rgb_if and rhc_hsv_if.
//
// Usage:
//   pixel  (sink)   : one item per handshake, red/green/blue, 8 bits unsigned each.
//   result (source) : one item per pixel, hue and saturation as 16-bit fractions,
//                     value as the largest component.
//   An item moves when valid and ready are both high at a rising edge of clk.
// Result path: the accepting edge loads the front stage; the item then moves through
//   the divider stages, and result.valid is the valid bit of the last stage.
// Throughput: one item per cycle unless stalled. Five register stages: a front
//   stage that finds max, min, sector and numerator, then four divider stages
//   that each produce four quotient bits of both 16-bit restoring divisions.
// Stall: each stage holds its item while the next one is full and not moving;
//   empty stages still fill, so bubbles close up and pixel.ready drops only
//   once every stage holds an item. Nothing is dropped or repeated.
// Reset (rst, synchronous, active high): clear all stage valid bits; the
//   block takes a pixel on the first cycle after reset.
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rhc_rgb_if.sink   pixel,
  rhc_hsv_if.source result
);

  localparam int LAST = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] vld;
  stage_t                stg [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] stage_ready;
  stage_t                front;

  // Front stage: components to max, min, delta and the hue numerator.
  logic [COMP_W-1:0] mx, mn, delta;
  logic              r_max, g_max;
  logic [HDIV_W-1:0] d2, d4, six_d, num;

  always_comb begin
    r_max = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
    g_max = !r_max && (pixel.green >= pixel.blue);
    if (r_max) begin
      mx = pixel.red;
    end else if (g_max) begin
      mx = pixel.green;
    end else begin
      mx = pixel.blue;
    end
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    delta = mx - mn;

    d2    = HDIV_W'({delta, 1'b0});
    d4    = HDIV_W'({delta, 2'b00});
    six_d = d4 + d2;

    // Work modulo 2^11: for nonzero delta every numerator ends up in 0 .. 6*delta-1.
    if (r_max) begin
      if (pixel.green >= pixel.blue) begin
        num = HDIV_W'(pixel.green) - HDIV_W'(pixel.blue);
      end else begin
        num = six_d + HDIV_W'(pixel.green) - HDIV_W'(pixel.blue);
      end
    end else if (g_max) begin
      num = d2 + HDIV_W'(pixel.blue) - HDIV_W'(pixel.red);
    end else begin
      num = d4 + HDIV_W'(pixel.red) - HDIV_W'(pixel.green);
    end

    front.value    = mx;
    front.sat_full = (mn == '0) && (mx != '0);
    front.sat_zero = (delta == '0);
    front.sat_rem  = delta;
    front.sat_q    = '0;
    front.hue_zero = (delta == '0);
    front.hue_rem  = num;
    front.hue_div  = six_d;
    front.hue_q    = '0;
  end

  // A stage can load when it is empty or its item moves on this cycle.
  always_comb begin
    stage_ready[LAST] = !vld[LAST] || result.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      stage_ready[i] = !vld[i] || stage_ready[i+1];
    end
  end

  assign pixel.ready = stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stage_ready[0]) vld[0] <= pixel.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (stage_ready[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0] && pixel.valid) stg[0] <= front;
  end

  // Divider stages: advance both quotients by four bits per stage.
  for (genvar g = 1; g < PIPE_DEPTH; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (stage_ready[g] && vld[g-1]) stg[g] <= div_advance(stg[g-1]);
    end
  end

  // Output: apply the grey, black and fully saturated cases.
  assign result.valid = vld[LAST];
  assign result.value = stg[LAST].value;
  assign result.hue   = stg[LAST].hue_zero ? '0 : stg[LAST].hue_q;

  always_comb begin
    if (stg[LAST].sat_full) begin
      result.saturation = SAT_HOLD;
    end else if (stg[LAST].sat_zero) begin
      result.saturation = '0;
    end else begin
      result.saturation = stg[LAST].sat_q;
    end
  end

endmodule

@@ rtl/core/rhc_checker.sv @@
// Port-level checker for the RGB to HSV converter and its bind statement.
// Depends on rhc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rhc_checker import rhc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HUE_W-1:0]  hue,
  input logic [SAT_W-1:0]  saturation,
  input logic [COMP_W-1:0] value
);

  `RHC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid && in_ready)
  `RHC_ASSERT(a_valid_holds, clk, rst, out_valid && !out_ready |=> out_valid)
  `RHC_ASSERT(a_payload_holds, clk, rst, out_valid && !out_ready |=> $stable({hue, saturation, value}))
  `RHC_ASSERT(a_black_pixel, clk, rst, out_valid && value == '0 |-> saturation == '0 && hue == '0)
  `RHC_ASSERT(a_grey_pixel, clk, rst, out_valid && saturation == '0 |-> hue == '0)

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixel.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .hue        (result.hue),
  .saturation (result.saturation),
  .value      (result.value)
);
